@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent holds, so the consequent must hold in the same cycle.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The antecedent holds, so the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/lcaq_pkg.sv @@
// Package with the transaction types and fixed field widths of the LCA query core.
package lcaq_pkg;

  localparam int NODE_W   = 10;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 26;
  localparam int PATH_W   = 27;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] weight;
  } request_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic [PATH_W-1:0] path_dist;
  } result_t;

  // Read and write strobes for the two state memories.
  typedef struct packed {
    logic anc_rd;
    logic anc_wr;
    logic info_rd;
    logic info_wr;
  } mem_ctl_t;

endpackage

@@ rtl/lcaq_mem.sv @@
// Ancestor table and per-node depth/distance memories with write-first forwarding.
module lcaq_mem #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10,
  localparam int NW = $clog2(NODES),
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1,
  localparam int AW = LW + NW,
  localparam int IW = LEVELS + lcaq_pkg::DIST_W
) (
  input  logic               clk,
  input  lcaq_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]      anc_rd_addr,
  input  logic [AW-1:0]      anc_wr_addr,
  input  logic [NW-1:0]      anc_wr_data,
  output logic [NW-1:0]      anc_rd_data,
  input  logic [NW-1:0]      info_rd_addr,
  input  logic [NW-1:0]      info_wr_addr,
  input  logic [IW-1:0]      info_wr_data,
  output logic [IW-1:0]      info_rd_data
);

  logic [NW-1:0] anc_mem  [2**AW];
  logic [IW-1:0] info_mem [2**NW];

  // A read of the entry being written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (ctl.anc_wr) begin
      anc_mem[anc_wr_addr] <= anc_wr_data;
    end
    if (ctl.anc_rd) begin
      if (ctl.anc_wr && (anc_wr_addr == anc_rd_addr)) begin
        anc_rd_data <= anc_wr_data;
      end else begin
        anc_rd_data <= anc_mem[anc_rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.info_wr) begin
      info_mem[info_wr_addr] <= info_wr_data;
    end
    if (ctl.info_rd) begin
      if (ctl.info_wr && (info_wr_addr == info_rd_addr)) begin
        info_rd_data <= info_wr_data;
      end else begin
        info_rd_data <= info_mem[info_rd_addr];
      end
    end
  end

endmodule

@@ rtl/lcaq_seq.sv @@
// Sequencer that loads nodes and walks the ancestor table to answer queries.
module lcaq_seq #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10,
  localparam int NW = $clog2(NODES),
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1,
  localparam int AW = LW + NW,
  localparam int IW = LEVELS + lcaq_pkg::DIST_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lcaq_pkg::request_t request,
  output logic               busy,
  output logic               done,
  output lcaq_pkg::result_t  result,
  output lcaq_pkg::mem_ctl_t ctl,
  output logic [AW-1:0]      anc_rd_addr,
  output logic [AW-1:0]      anc_wr_addr,
  output logic [NW-1:0]      anc_wr_data,
  input  logic [NW-1:0]      anc_rd_data,
  output logic [NW-1:0]      info_rd_addr,
  output logic [NW-1:0]      info_wr_addr,
  output logic [IW-1:0]      info_wr_data,
  input  logic [IW-1:0]      info_rd_data
);

  localparam int DW = lcaq_pkg::DIST_W;
  localparam int PW = lcaq_pkg::PATH_W;
  localparam int NI = lcaq_pkg::NODE_W;
  localparam int unsigned RECIP = ((2 ** 20) + NODES - 1) / NODES;
  localparam logic [30:0]   RECIP_W  = 31'(RECIP);
  localparam logic [26:0]   NODES_W  = 27'(NODES);
  localparam logic [LW-1:0] LAST_LVL = LW'(LEVELS - 1);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_RED1  = 17'h00002,
    S_RED2  = 17'h00004,
    S_LROOT = 17'h00008,
    S_LPAR  = 17'h00010,
    S_LINFO = 17'h00020,
    S_LLIFT = 17'h00040,
    S_QRDA  = 17'h00080,
    S_QRDB  = 17'h00100,
    S_QCMP  = 17'h00200,
    S_QUP   = 17'h00400,
    S_QUPW  = 17'h00800,
    S_QEQ   = 17'h01000,
    S_QDNX  = 17'h02000,
    S_QDNY  = 17'h04000,
    S_QFIN  = 17'h08000,
    S_QDIST = 17'h10000
  } state_t;

  state_t                  state, state_next;
  logic [LW-1:0]           lvl, lvl_next;
  lcaq_pkg::cmd_t          cmd, cmd_next;
  logic [NI-1:0]           raw_a, raw_a_next;
  logic [NI-1:0]           raw_b, raw_b_next;
  logic [lcaq_pkg::WEIGHT_W-1:0] wgt, wgt_next;
  logic [NI-1:0]           qa, qa_next;
  logic [NI-1:0]           qb, qb_next;
  logic [NW-1:0]           x, x_next;
  logic [NW-1:0]           y, y_next;
  logic [NW-1:0]           nx, nx_next;
  logic [LEVELS-1:0]       dep_a, dep_a_next;
  logic [LEVELS-1:0]       diff, diff_next;
  logic [DW-1:0]           dist_a, dist_a_next;
  logic [DW-1:0]           dist_b, dist_b_next;
  logic                    done_next;
  lcaq_pkg::result_t       result_next;

  logic [30:0]       prod_a, prod_b;
  logic [NW-1:0]     red_a, red_b;
  logic [LEVELS-1:0] rd_depth;
  logic [DW-1:0]     rd_dist;
  logic [NW-1:0]     step_x;

  // Remainder of a node index by NODES from a reciprocal quotient, with one correction.
  function automatic logic [NW-1:0] reduce_index(input logic [NI-1:0] raw,
                                                 input logic [NI-1:0] q);
    logic [26:0] r;
    r = 27'(raw) - 27'(q) * NODES_W;
    if (r >= NODES_W) begin
      r = r - NODES_W;
    end
    return NW'(r);
  endfunction

  assign prod_a   = 31'(raw_a) * RECIP_W;
  assign prod_b   = 31'(raw_b) * RECIP_W;
  assign red_a    = reduce_index(raw_a, qa);
  assign red_b    = reduce_index(raw_b, qb);
  assign rd_depth = info_rd_data[IW-1:DW];
  assign rd_dist  = info_rd_data[DW-1:0];
  assign busy     = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    lvl_next     = lvl;
    cmd_next     = cmd;
    raw_a_next   = raw_a;
    raw_b_next   = raw_b;
    wgt_next     = wgt;
    qa_next      = qa;
    qb_next      = qb;
    x_next       = x;
    y_next       = y;
    nx_next      = nx;
    dep_a_next   = dep_a;
    diff_next    = diff;
    dist_a_next  = dist_a;
    dist_b_next  = dist_b;
    done_next    = 1'b0;
    result_next  = result;
    ctl          = '0;
    anc_rd_addr  = {lvl, x};
    anc_wr_addr  = {lvl, x};
    anc_wr_data  = y;
    info_rd_addr = x;
    info_wr_addr = x;
    info_wr_data = '0;
    step_x       = x;

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_next   = request.cmd;
          raw_a_next = request.node_a;
          raw_b_next = request.node_b;
          wgt_next   = request.weight;
          state_next = S_RED1;
        end
      end
      S_RED1: begin
        qa_next    = prod_a[29:20];
        qb_next    = prod_b[29:20];
        state_next = S_RED2;
      end
      S_RED2: begin
        x_next   = red_a;
        y_next   = red_b;
        lvl_next = '0;
        if (cmd == lcaq_pkg::CMD_LOAD) begin
          state_next = (red_a == red_b) ? S_LROOT : S_LPAR;
        end else begin
          state_next = S_QRDA;
        end
      end
      S_LROOT: begin
        ctl.anc_wr  = 1'b1;
        anc_wr_data = x;
        if (lvl == '0) begin
          ctl.info_wr = 1'b1;
        end
        if (lvl == LAST_LVL) begin
          state_next = S_IDLE;
        end else begin
          lvl_next = lvl + LW'(1);
        end
      end
      S_LPAR: begin
        ctl.info_rd  = 1'b1;
        info_rd_addr = y;
        state_next   = S_LINFO;
      end
      S_LINFO: begin
        ctl.info_wr  = 1'b1;
        info_wr_data = {rd_depth + LEVELS'(1), rd_dist + DW'(wgt)};
        ctl.anc_wr   = 1'b1;
        if (LAST_LVL != '0) begin
          ctl.anc_rd  = 1'b1;
          anc_rd_addr = {lvl, y};
          lvl_next    = LW'(1);
          state_next  = S_LLIFT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_LLIFT: begin
        ctl.anc_wr  = 1'b1;
        anc_wr_data = anc_rd_data;
        if (lvl == LAST_LVL) begin
          state_next = S_IDLE;
        end else begin
          ctl.anc_rd  = 1'b1;
          anc_rd_addr = {lvl, anc_rd_data};
          lvl_next    = lvl + LW'(1);
        end
      end
      S_QRDA: begin
        ctl.info_rd = 1'b1;
        state_next  = S_QRDB;
      end
      S_QRDB: begin
        dep_a_next   = rd_depth;
        dist_a_next  = rd_dist;
        ctl.info_rd  = 1'b1;
        info_rd_addr = y;
        state_next   = S_QCMP;
      end
      S_QCMP: begin
        dist_b_next = rd_dist;
        if (dep_a < rd_depth) begin
          x_next    = y;
          y_next    = x;
          diff_next = rd_depth - dep_a;
        end else begin
          diff_next = dep_a - rd_depth;
        end
        lvl_next   = '0;
        state_next = S_QUP;
      end
      S_QUP: begin
        if (diff[lvl]) begin
          ctl.anc_rd = 1'b1;
          state_next = S_QUPW;
        end else if (lvl == LAST_LVL) begin
          state_next = S_QEQ;
        end else begin
          lvl_next = lvl + LW'(1);
        end
      end
      S_QUPW: begin
        x_next = anc_rd_data;
        if (lvl == LAST_LVL) begin
          state_next = S_QEQ;
        end else begin
          lvl_next   = lvl + LW'(1);
          state_next = S_QUP;
        end
      end
      S_QEQ: begin
        if (x == y) begin
          nx_next     = x;
          ctl.info_rd = 1'b1;
          state_next  = S_QDIST;
        end else begin
          ctl.anc_rd  = 1'b1;
          anc_rd_addr = {LAST_LVL, x};
          lvl_next    = LAST_LVL;
          state_next  = S_QDNX;
        end
      end
      S_QDNX: begin
        nx_next     = anc_rd_data;
        ctl.anc_rd  = 1'b1;
        anc_rd_addr = {lvl, y};
        state_next  = S_QDNY;
      end
      S_QDNY: begin
        if (nx != anc_rd_data) begin
          x_next = nx;
          y_next = anc_rd_data;
          step_x = nx;
        end
        ctl.anc_rd = 1'b1;
        if (lvl == '0) begin
          anc_rd_addr = {lvl, step_x};
          state_next  = S_QFIN;
        end else begin
          anc_rd_addr = {lvl - LW'(1), step_x};
          lvl_next    = lvl - LW'(1);
          state_next  = S_QDNX;
        end
      end
      S_QFIN: begin
        nx_next      = anc_rd_data;
        ctl.info_rd  = 1'b1;
        info_rd_addr = anc_rd_data;
        state_next   = S_QDIST;
      end
      S_QDIST: begin
        result_next.ancestor  = NI'(nx);
        result_next.path_dist = PW'(dist_a) + PW'(dist_b) - {rd_dist, 1'b0};
        done_next             = 1'b1;
        state_next            = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    lvl    <= lvl_next;
    cmd    <= cmd_next;
    raw_a  <= raw_a_next;
    raw_b  <= raw_b_next;
    wgt    <= wgt_next;
    qa     <= qa_next;
    qb     <= qb_next;
    x      <= x_next;
    y      <= y_next;
    nx     <= nx_next;
    dep_a  <= dep_a_next;
    diff   <= diff_next;
    dist_a <= dist_a_next;
    dist_b <= dist_b_next;
    result <= result_next;
  end

endmodule

@@ rtl/tree_lca_distance_query_core.sv @@
// Loads give no result transaction.
// Queries run from acceptance to the done strobe, reading the ancestor table while
// lifting up and then walking down the levels.
// One transaction is worked at a time; busy is high until the next one may start.
// Synchronous reset returns the sequencer to idle; the memories are not cleared.
// The result is shown for one cycle with done, and the receiver cannot stall it.
module tree_lca_distance_query_core #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lcaq_pkg::request_t request,
  output logic               busy,
  output logic               done,
  output lcaq_pkg::result_t  result
);

  // Node indices take log2(NODES) bits; the ancestor table is addressed by
  // level in the upper bits and node in the lower bits.
  localparam int NW = $clog2(NODES);
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int AW = LW + NW;
  localparam int IW = LEVELS + lcaq_pkg::DIST_W;

  lcaq_pkg::mem_ctl_t ctl;
  logic [AW-1:0]      anc_rd_addr;
  logic [AW-1:0]      anc_wr_addr;
  logic [NW-1:0]      anc_wr_data;
  logic [NW-1:0]      anc_rd_data;
  logic [NW-1:0]      info_rd_addr;
  logic [NW-1:0]      info_wr_addr;
  logic [IW-1:0]      info_wr_data;
  logic [IW-1:0]      info_rd_data;

  // The sequencer accepts a transaction when start is high and busy is low,
  // reduces both node indices modulo NODES, and then either fills the new
  // node's depth, root distance and ancestor levels or runs the lifting walk.
  lcaq_seq #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .request      (request),
    .busy         (busy),
    .done         (done),
    .result       (result),
    .ctl          (ctl),
    .anc_rd_addr  (anc_rd_addr),
    .anc_wr_addr  (anc_wr_addr),
    .anc_wr_data  (anc_wr_data),
    .anc_rd_data  (anc_rd_data),
    .info_rd_addr (info_rd_addr),
    .info_wr_addr (info_wr_addr),
    .info_wr_data (info_wr_data),
    .info_rd_data (info_rd_data)
  );

  // Both memories have registered read data and forward a write to a read of the
  // same entry in the same cycle, which covers a load whose ancestor chain loops
  // back onto the node being loaded.
  lcaq_mem #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_mem (
    .clk          (clk),
    .ctl          (ctl),
    .anc_rd_addr  (anc_rd_addr),
    .anc_wr_addr  (anc_wr_addr),
    .anc_wr_data  (anc_wr_data),
    .anc_rd_data  (anc_rd_data),
    .info_rd_addr (info_rd_addr),
    .info_wr_addr (info_wr_addr),
    .info_wr_data (info_wr_data),
    .info_rd_data (info_rd_data)
  );

endmodule

@@ rtl/lcaq_checker.sv @@
// Port-level checker for the LCA query core and its bind to the top level.
`include "assert_macros.svh"

module lcaq_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input lcaq_pkg::request_t request,
  input logic               busy,
  input logic               done,
  input lcaq_pkg::result_t  result
);

  logic accept;
  assign accept = start && !busy;

  // An accepted transaction keeps the core busy in the following cycle.
  `ASSERT_NEXT(a_accept_busy, accept, busy)
  // No result is shown in the cycle after an acceptance.
  `ASSERT_NEXT(a_accept_no_done, accept, !done)
  // A result closes its transaction, so the core is free while it is shown.
  `ASSERT_SAME(a_done_idle, done, !busy && $past(busy))
  // Each query gives a single one-cycle strobe.
  `ASSERT_NEXT(a_done_single, done, !done)

endmodule

bind tree_lca_distance_query_core lcaq_checker u_checker (.*);

@@ verif/tb.sv @@
// Self-checking testbench for the binary-lifting LCA and path-distance query core.
module tb;

  localparam int NODES  = 1024;
  localparam int LEVELS = 10;
  localparam int NODE_W   = lcaq_pkg::NODE_W;
  localparam int WEIGHT_W = lcaq_pkg::WEIGHT_W;
  localparam int DIST_W   = lcaq_pkg::DIST_W;
  localparam int PATH_W   = lcaq_pkg::PATH_W;
  // Extra cycles allowed after the last answer, sized from the slowest query.
  localparam int DRAIN_CYCLES = 4 * LEVELS + 16;
  localparam int RANDOM_ITEMS = 300;

  // One stimulus transaction. A directed row may carry a hand-written answer;
  // otherwise the answer comes from the tree model below.
  typedef struct packed {
    lcaq_pkg::request_t req;
    logic               known;
    lcaq_pkg::result_t  res;
  } txn_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  lcaq_pkg::request_t request = '0;
  logic               busy;
  logic               done;
  lcaq_pkg::result_t  result;

  tree_lca_distance_query_core #(
    .NODES (NODES),
    .LEVELS(LEVELS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  // Tree model: ancestor tables, depth and distance to the root, per node.
  logic [NODE_W-1:0] lift_tbl     [LEVELS][NODES];
  logic [NODE_W-1:0] depth_of     [NODES];
  logic [DIST_W-1:0] dist_to_root [NODES];

  // Nodes loaded since reset. Queries and parents are only drawn from these,
  // since the core's memories hold garbage until a node has been written.
  bit node_live [NODES];
  int live_nodes[$];

  lcaq_pkg::result_t answers_due[$];
  int                bad_results = 0;
  int                items_sent = 0;
  bit                calm = 1'b0;

  // Loading a node. A node that names itself as parent becomes a root. Any
  // other node inherits depth and distance from its parent, and each level of
  // its ancestor table is one level down from the previous level's ancestor.
  // Reloading a node leaves its descendants' tables stale on purpose, exactly
  // as the hardware does.
  function automatic void tree_load(int v, int p, logic [WEIGHT_W-1:0] w);
    int mid;
    if (v == p) begin
      for (int i = 0; i < LEVELS; i++) lift_tbl[i][v] = v[NODE_W-1:0];
      depth_of[v]     = '0;
      dist_to_root[v] = '0;
    end else begin
      lift_tbl[0][v]  = p[NODE_W-1:0];
      depth_of[v]     = depth_of[p] + 1'b1;
      dist_to_root[v] = dist_to_root[p] + DIST_W'(w);
      for (int i = 1; i < LEVELS; i++) begin
        mid = int'(lift_tbl[i - 1][v]);
        lift_tbl[i][v] = lift_tbl[i - 1][mid];
      end
    end
    if (!node_live[v]) begin
      node_live[v] = 1'b1;
      live_nodes.push_back(v);
    end
  endfunction

  // Query: lift the deeper node to the other's depth, then walk both up from
  // the top level while their ancestors differ. The distance is taken modulo
  // 2^PATH_W, which matters only once the tree has gone inconsistent.
  function automatic lcaq_pkg::result_t tree_query(int a, int b);
    int                x, y, swap_tmp, nx, ny, lca;
    logic [NODE_W-1:0] diff;
    logic [PATH_W-1:0] da, db, dl;
    lcaq_pkg::result_t ans;
    x = a;
    y = b;
    if (depth_of[x] < depth_of[y]) begin
      swap_tmp = x;
      x = y;
      y = swap_tmp;
    end
    diff = depth_of[x] - depth_of[y];
    for (int i = 0; i < LEVELS; i++)
      if (diff[i]) x = int'(lift_tbl[i][x]);
    if (x == y) begin
      lca = x;
    end else begin
      for (int i = LEVELS - 1; i >= 0; i--) begin
        nx = int'(lift_tbl[i][x]);
        ny = int'(lift_tbl[i][y]);
        if (nx != ny) begin
          x = nx;
          y = ny;
        end
      end
      lca = int'(lift_tbl[0][x]);
    end
    da = PATH_W'(dist_to_root[a]);
    db = PATH_W'(dist_to_root[b]);
    dl = PATH_W'(dist_to_root[lca]);
    ans.ancestor  = lca[NODE_W-1:0];
    ans.path_dist = da + db - (dl << 1);
    return ans;
  endfunction

  function automatic txn_t txn(input lcaq_pkg::cmd_t c, input int a, input int b,
                               input int w, input bit known = 1'b0, input int anc = 0,
                               input int pdist = 0);
    txn_t t;
    t.req.cmd       = c;
    t.req.node_a    = a[NODE_W-1:0];
    t.req.node_b    = b[NODE_W-1:0];
    t.req.weight    = w[WEIGHT_W-1:0];
    t.known         = known;
    t.res.ancestor  = anc[NODE_W-1:0];
    t.res.path_dist = pdist[PATH_W-1:0];
    return t;
  endfunction

  // Edge weights lean on the extremes so that the distance sums carry hard.
  function automatic int rand_weight();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 16'hFFFF;
    return $urandom_range(0, 16'hFFFF);
  endfunction

  // Idle gap before a transaction: mostly none or short, now and then long.
  // During a calm stretch the sender runs back to back.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one transaction and hold it until the core takes it, which is the
  // first rising edge with busy low. The model is updated at that edge, so the
  // expected answers stay in the order the core receives its queries. When no
  // gap follows, start simply stays high into the next transaction.
  task automatic issue(input txn_t t);
    int idle;
    idle = pick_gap();
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    start   <= 1'b1;
    request <= t.req;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (t.req.cmd == lcaq_pkg::CMD_LOAD) begin
      tree_load(int'(t.req.node_a), int'(t.req.node_b), t.req.weight);
    end else if (t.known) begin
      answers_due.push_back(t.res);
    end else begin
      answers_due.push_back(tree_query(int'(t.req.node_a), int'(t.req.node_b)));
    end
    items_sent++;
  endtask

  // The result is valid for exactly one cycle with done; it is sampled at the
  // edge that closes that cycle and compared against the oldest answer due.
  always @(posedge clk) begin : check_results
    lcaq_pkg::result_t want;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("[%0t] unexpected result: ancestor %0d path_dist %0d",
                   $realtime, result.ancestor, result.path_dist);
      end else begin
        want = answers_due.pop_front();
        if (result.ancestor !== want.ancestor || result.path_dist !== want.path_dist) begin
          bad_results++;
          if (bad_results <= 10)
            $display("[%0t] mismatch: ancestor exp %0d got %0d, path_dist exp %0d got %0d",
                     $realtime, want.ancestor, result.ancestor,
                     want.path_dist, result.path_dist);
        end
      end
    end
  end

  initial begin : stimulus
    txn_t plan[$];
    int   grove[$];
    int   cur, prev, nxt, v, p, root, span, r, tries, random_end;
    bit   deep;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Hand-written answers only where they are obvious: a node
    // against itself, a child against its root, and siblings under one parent.
    plan.push_back(txn(lcaq_pkg::CMD_LOAD,     0,    0, 16'hFFFF));    // root; weight ignored
    plan.push_back(txn(lcaq_pkg::CMD_QUERY,    0,    0, 16'hFFFF, 1'b1, 0, 0));
    plan.push_back(txn(lcaq_pkg::CMD_LOAD,  1023,    0, 16'hFFFF));
    plan.push_back(txn(lcaq_pkg::CMD_QUERY, 1023,    0, 0, 1'b1, 0, 16'hFFFF));
    plan.push_back(txn(lcaq_pkg::CMD_QUERY,    0, 1023, 0, 1'b1, 0, 16'hFFFF));
    plan.push_back(txn(lcaq_pkg::CMD_LOAD,   512,    0, 0));
    plan.push_back(txn(lcaq_pkg::CMD_QUERY,  512, 1023, 0, 1'b1, 0, 16'hFFFF));
    plan.push_back(txn(lcaq_pkg::CMD_LOAD,   341, 1023, 1));
    plan.push_back(txn(lcaq_pkg::CMD_LOAD,   682, 1023, 16'h8000));
    plan.push_back(txn(lcaq_pkg::CMD_QUERY,  341,  682, 0, 1'b1, 1023, 32'h8001));
    plan.push_back(txn(lcaq_pkg::CMD_QUERY,  341,  341, 0, 1'b1, 341, 0));
    plan.push_back(txn(lcaq_pkg::CMD_LOAD,     1,  341, 16'h5555));
    plan.push_back(txn(lcaq_pkg::CMD_LOAD,     2,  682, 16'hAAAA));
    plan.push_back(txn(lcaq_pkg::CMD_QUERY,    1,    2, 16'hFFFF));
    plan.push_back(txn(lcaq_pkg::CMD_QUERY,    1,  512, 0));
    // A second root, then a query across the two trees.
    plan.push_back(txn(lcaq_pkg::CMD_LOAD,  1000, 1000, 1234));
    plan.push_back(txn(lcaq_pkg::CMD_QUERY, 1000, 1000, 0, 1'b1, 1000, 0));
    plan.push_back(txn(lcaq_pkg::CMD_QUERY,    1, 1000, 0));
    // Moving an inner node leaves its descendants with stale tables.
    plan.push_back(txn(lcaq_pkg::CMD_LOAD,  1023,  512, 7));
    plan.push_back(txn(lcaq_pkg::CMD_QUERY,    1,    2, 0));
    plan.push_back(txn(lcaq_pkg::CMD_QUERY, 1023,  512, 0));
    plan.push_back(txn(lcaq_pkg::CMD_LOAD,     0,    0, 99));
    plan.push_back(txn(lcaq_pkg::CMD_QUERY,    1,    0, 0));
    plan.push_back(txn(lcaq_pkg::CMD_LOAD,     3,    3, 16'hFFFF));
    plan.push_back(txn(lcaq_pkg::CMD_QUERY,    3,    0, 0));
    foreach (plan[i]) issue(plan[i]);

    // Deep chain. Two nodes are reloaded under each other in turn, each time
    // one level deeper with the heaviest edge, until the depth passes
    // 2^(LEVELS-1). Queries along the way lift across every level of the tables.
    issue(txn(lcaq_pkg::CMD_LOAD, 100, 100, rand_weight()));
    cur  = 101;
    prev = 100;
    for (int k = 0; k < 520; k++) begin
      issue(txn(lcaq_pkg::CMD_LOAD, cur, prev, 16'hFFFF));
      if (k % 40 == 39) begin
        issue(txn(lcaq_pkg::CMD_QUERY, cur, 100, $urandom_range(0, 16'hFFFF)));
        issue(txn(lcaq_pkg::CMD_QUERY, prev, cur, $urandom_range(0, 16'hFFFF)));
      end
      nxt  = (k == 0) ? 102 : prev;
      prev = cur;
      cur  = nxt;
    end

    // Random part, in episodes. Each episode grows one fresh tree from a new
    // root and queries pairs inside it. Deep episodes favor chaining onto the
    // newest node so the upper lifting levels get used. A few transactions are
    // noise: pairs from anywhere, or nodes moved under arbitrary parents.
    random_end = items_sent + RANDOM_ITEMS;
    while (items_sent < random_end) begin
      calm = ($urandom_range(0, 5) == 0);
      deep = ($urandom_range(0, 4) == 0);
      span = deep ? $urandom_range(60, 140) : $urandom_range(8, 40);
      root = $urandom_range(0, NODES - 1);
      issue(txn(lcaq_pkg::CMD_LOAD, root, root, rand_weight()));
      grove.delete();
      grove.push_back(root);
      for (int s = 0; s < span; s++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          v = live_nodes[$urandom_range(0, live_nodes.size() - 1)];
          p = live_nodes[$urandom_range(0, live_nodes.size() - 1)];
          if ($urandom_range(0, 1))
            issue(txn(lcaq_pkg::CMD_QUERY, v, p, $urandom_range(0, 16'hFFFF)));
          else
            issue(txn(lcaq_pkg::CMD_LOAD, $urandom_range(0, NODES - 1), v, rand_weight()));
        end else if (r < (deep ? 85 : 55)) begin
          // Prefer a node not yet loaded, so that early on most trees are clean.
          v = $urandom_range(0, NODES - 1);
          for (tries = 0; tries < 4 && node_live[v]; tries++)
            v = $urandom_range(0, NODES - 1);
          if ($urandom_range(0, 99) < (deep ? 90 : 50))
            p = grove[grove.size() - 1];
          else
            p = grove[$urandom_range(0, grove.size() - 1)];
          issue(txn(lcaq_pkg::CMD_LOAD, v, p, rand_weight()));
          grove.push_back(v);
        end else begin
          v = grove[$urandom_range(0, grove.size() - 1)];
          p = ($urandom_range(0, 9) == 0) ? v : grove[$urandom_range(0, grove.size() - 1)];
          issue(txn(lcaq_pkg::CMD_QUERY, v, p, $urandom_range(0, 16'hFFFF)));
        end
      end
    end

    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_results == 0 && answers_due.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("timeout with %0d query answers still due", answers_due.size());
    $display("FAILURE");
    $finish;
  end

endmodule
